// ===== rtl/pra_pkg.sv =====
// Shared types, constants and tables for the point rotation block.
package pra_pkg;

	localparam int CORDIC_STEPS_DEF = 18;
	localparam int TAB_LEN = 30;
	localparam int NROT = 5;
	localparam int CX = 37;
	localparam int AW = 28;
	localparam int CW = 30;
	localparam int PW = 36;
	localparam int COEF_FRAC = 28;
	localparam int QDEPTH = 4;

	localparam logic signed [AW-1:0] ANG_FULL = AW'(23592960);
	localparam logic signed [AW-1:0] ANG_HALF = AW'(11796480);
	localparam logic signed [AW-1:0] ANG_QUARTER = AW'(5898240);
	localparam logic signed [31:0] INV_GAIN = 32'sd652032874;

	localparam logic [2:0] REG_SX = 3'd0;
	localparam logic [2:0] REG_SY = 3'd1;
	localparam logic [2:0] REG_SZ = 3'd2;
	localparam logic [2:0] REG_EX = 3'd3;
	localparam logic [2:0] REG_EY = 3'd4;
	localparam logic [2:0] REG_EZ = 3'd5;
	localparam logic [2:0] REG_TURN = 3'd6;

	localparam logic [2:0] JOB_ZA = 3'd0;
	localparam logic [2:0] JOB_LEN = 3'd1;
	localparam logic [2:0] JOB_XA = 3'd2;
	localparam logic [2:0] JOB_R0 = 3'd3;
	localparam logic [2:0] JOB_R1 = 3'd4;
	localparam logic [2:0] JOB_R2 = 3'd5;
	localparam logic [2:0] JOB_R3 = 3'd6;
	localparam logic [2:0] JOB_R4 = 3'd7;

	typedef logic signed [CW-1:0] coef_w_t;

	typedef struct packed {
		coef_w_t [NROT-1:0] c;
		coef_w_t [NROT-1:0] s;
	} coef_t;

	typedef struct packed {
		logic [31:0] w;
		logic signed [32:0] dz;
		logic signed [32:0] dy;
		logic signed [32:0] dx;
	} point_t;

	typedef enum logic [1:0] {
		SEQ_IDLE,
		SEQ_LOAD,
		SEQ_RUN,
		SEQ_FIN
	} seq_state_t;

	// atan(2^-i) in 1/65536 degree
	function automatic logic [22:0] atan_tab(input logic [4:0] i);
		logic [22:0] r;
		unique case (i)
			5'd0: r = 23'd2949120;
			5'd1: r = 23'd1740967;
			5'd2: r = 23'd919879;
			5'd3: r = 23'd466945;
			5'd4: r = 23'd234379;
			5'd5: r = 23'd117304;
			5'd6: r = 23'd58666;
			5'd7: r = 23'd29335;
			5'd8: r = 23'd14668;
			5'd9: r = 23'd7334;
			5'd10: r = 23'd3667;
			5'd11: r = 23'd1833;
			5'd12: r = 23'd917;
			5'd13: r = 23'd458;
			5'd14: r = 23'd229;
			5'd15: r = 23'd115;
			5'd16: r = 23'd57;
			5'd17: r = 23'd29;
			5'd18: r = 23'd14;
			5'd19: r = 23'd7;
			5'd20: r = 23'd4;
			5'd21: r = 23'd2;
			5'd22: r = 23'd1;
			default: r = 23'd0;
		endcase
		return r;
	endfunction

endpackage

// ===== rtl/pra_coef.sv =====
// Coefficient sequencer: axis angles and rotation sine/cosine from one shared CORDIC.
module pra_coef #(
	parameter int STEPS = pra_pkg::CORDIC_STEPS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic signed [31:0]  sx,
	input  logic signed [31:0]  sy,
	input  logic signed [31:0]  sz,
	input  logic signed [31:0]  ex,
	input  logic signed [31:0]  ey,
	input  logic signed [31:0]  ez,
	input  logic signed [25:0]  turn,
	output logic                ready,
	output pra_pkg::coef_t      coef
);
	localparam int CX = pra_pkg::CX;
	localparam int AW = pra_pkg::AW;
	localparam int CW = pra_pkg::CW;
	localparam int IW = (STEPS > 1) ? $clog2(STEPS) : 1;
	localparam int LP = CX + 32;

	pra_pkg::seq_state_t state_q, state_d;
	logic dirty_q;
	logic [2:0] j_q;
	logic [IW-1:0] i_q;
	logic signed [CX-1:0] x_q, y_q, len_q;
	logic signed [AW-1:0] z_q, za_q, xa_q;
	logic skip_q, flip_q;
	pra_pkg::coef_t coef_q;

	logic signed [32:0] vx, vy, vz;
	logic signed [CX-1:0] avx, avy, avz;
	logic signed [CX-1:0] x_ld, y_ld;
	logic signed [AW-1:0] z_ld, za_h, za_f, xa_f, t_sel, t0, t1, t2, t3;
	logic skip_ld, flip_ld, vec, dir;
	logic signed [CX-1:0] xs, ys, x_nx, y_nx, xr, yr;
	logic signed [AW-1:0] tab, z_abs;
	logic signed [LP-1:0] lp;
	pra_pkg::coef_w_t cr, sr;
	logic [2:0] ridx;

	assign vx = 33'(ex) - 33'(sx);
	assign vy = 33'(ey) - 33'(sy);
	assign vz = 33'(ez) - 33'(sz);
	assign avx = vx[32] ? -CX'(vx) : CX'(vx);
	assign avy = vy[32] ? -CX'(vy) : CX'(vy);
	assign avz = vz[32] ? -CX'(vz) : CX'(vz);

	assign za_h = vy[32] ? pra_pkg::ANG_HALF - za_q : za_q;
	assign za_f = vx[32] ? -za_h : za_h;
	assign xa_f = vz[32] ? pra_pkg::ANG_HALF - xa_q : xa_q;

	always_comb begin
		unique case (j_q)
			pra_pkg::JOB_R0: t_sel = za_f;
			pra_pkg::JOB_R1: t_sel = xa_f;
			pra_pkg::JOB_R2: t_sel = AW'(turn);
			pra_pkg::JOB_R3: t_sel = -xa_f;
			pra_pkg::JOB_R4: t_sel = -za_f;
			default: t_sel = '0;
		endcase
	end

	// Reduce to [-90, 90] degrees, recording a half turn
	always_comb begin
		t0 = (t_sel < 0) ? t_sel + pra_pkg::ANG_FULL : t_sel;
		t1 = (t0 < 0) ? t0 + pra_pkg::ANG_FULL : t0;
		t2 = (t1 >= pra_pkg::ANG_FULL) ? t1 - pra_pkg::ANG_FULL : t1;
		if (t2 > pra_pkg::ANG_HALF) t2 = t2 - pra_pkg::ANG_FULL;
		flip_ld = 1'b0;
		t3 = t2;
		if (t2 > pra_pkg::ANG_QUARTER) begin
			t3 = t2 - pra_pkg::ANG_HALF;
			flip_ld = 1'b1;
		end else if (t2 < -pra_pkg::ANG_QUARTER) begin
			t3 = t2 + pra_pkg::ANG_HALF;
			flip_ld = 1'b1;
		end
	end

	always_comb begin
		unique case (j_q)
			pra_pkg::JOB_ZA: begin
				x_ld = avy; y_ld = avx; z_ld = '0; skip_ld = (vy == '0);
			end
			pra_pkg::JOB_LEN: begin
				x_ld = avx; y_ld = avy; z_ld = '0; skip_ld = 1'b0;
			end
			pra_pkg::JOB_XA: begin
				x_ld = avz; y_ld = len_q; z_ld = '0; skip_ld = (vz == '0);
			end
			default: begin
				x_ld = CX'(pra_pkg::INV_GAIN); y_ld = '0; z_ld = t3; skip_ld = 1'b0;
			end
		endcase
	end

	assign vec = (j_q == pra_pkg::JOB_ZA) || (j_q == pra_pkg::JOB_LEN) ||
		(j_q == pra_pkg::JOB_XA);
	assign dir = vec ? !y_q[CX-1] : z_q[AW-1];
	assign xs = x_q >>> i_q;
	assign ys = y_q >>> i_q;
	assign tab = AW'(pra_pkg::atan_tab(5'(i_q)));
	assign x_nx = dir ? x_q + ys : x_q - ys;
	assign y_nx = dir ? y_q - xs : y_q + xs;
	assign z_abs = z_q[AW-1] ? -z_q : z_q;
	assign lp = LP'(x_q) * LP'(pra_pkg::INV_GAIN) + (LP'(1) <<< 29);
	assign xr = (x_q + CX'(2)) >>> 2;
	assign yr = (y_q + CX'(2)) >>> 2;
	assign cr = flip_q ? -CW'(xr) : CW'(xr);
	assign sr = flip_q ? -CW'(yr) : CW'(yr);
	assign ridx = 3'(j_q - pra_pkg::JOB_R0);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			pra_pkg::SEQ_IDLE: if (dirty_q) state_d = pra_pkg::SEQ_LOAD;
			pra_pkg::SEQ_LOAD: state_d = skip_ld ? pra_pkg::SEQ_FIN : pra_pkg::SEQ_RUN;
			pra_pkg::SEQ_RUN: if (i_q == IW'(STEPS - 1)) state_d = pra_pkg::SEQ_FIN;
			pra_pkg::SEQ_FIN: begin
				state_d = (j_q == pra_pkg::JOB_R4) ? pra_pkg::SEQ_IDLE : pra_pkg::SEQ_LOAD;
			end
			default: state_d = pra_pkg::SEQ_IDLE;
		endcase
	end

	always_comb begin
		ready = (state_q == pra_pkg::SEQ_IDLE) && !dirty_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pra_pkg::SEQ_IDLE;
			dirty_q <= 1'b1;
			j_q <= pra_pkg::JOB_ZA;
			i_q <= '0;
		end else begin
			state_q <= state_d;
			if (start) dirty_q <= 1'b1;
			else if (state_q == pra_pkg::SEQ_IDLE) dirty_q <= 1'b0;
			if (state_q == pra_pkg::SEQ_IDLE) j_q <= pra_pkg::JOB_ZA;
			else if (state_q == pra_pkg::SEQ_FIN) j_q <= j_q + 3'd1;
			if (state_q == pra_pkg::SEQ_RUN) i_q <= i_q + IW'(1);
			else i_q <= '0;
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			pra_pkg::SEQ_LOAD: begin
				x_q <= x_ld;
				y_q <= y_ld;
				z_q <= z_ld;
				skip_q <= skip_ld;
				flip_q <= flip_ld;
			end
			pra_pkg::SEQ_RUN: begin
				x_q <= x_nx;
				y_q <= y_nx;
				z_q <= dir ? z_q + tab : z_q - tab;
			end
			pra_pkg::SEQ_FIN: begin
				unique case (j_q)
					pra_pkg::JOB_ZA: za_q <= skip_q ? pra_pkg::ANG_QUARTER : z_abs;
					pra_pkg::JOB_LEN: len_q <= CX'(lp >>> 30);
					pra_pkg::JOB_XA: xa_q <= skip_q ? pra_pkg::ANG_QUARTER : z_abs;
					default: begin
						coef_q.c[ridx] <= cr;
						coef_q.s[ridx] <= sr;
					end
				endcase
			end
			default: ;
		endcase
	end

	assign coef = coef_q;

	a_restart: assert property (@(posedge clk) disable iff (!arst_n)
		start |=> !ready)
		else $error("coefficient pass not restarted");
	a_fin_step: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == pra_pkg::SEQ_RUN && i_q != IW'(STEPS - 1)) |=> state_q == pra_pkg::SEQ_RUN)
		else $error("CORDIC run ended early");
	a_idle_job: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == pra_pkg::SEQ_FIN && j_q == pra_pkg::JOB_R4) |=> state_q == pra_pkg::SEQ_IDLE)
		else $error("sequencer missed end of pass");

endmodule

// ===== rtl/pra_queue.sv =====
// Short request queue between the front and the rotation pipeline.
module pra_queue #(
	parameter int W = 1,
	parameter int DEPTH = pra_pkg::QDEPTH
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] wdata,
	input  logic         pop,
	output logic [W-1:0] rdata,
	output logic         full,
	output logic         nonempty
);
	localparam int AB = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CB = $clog2(DEPTH + 1);

	logic [W-1:0] mem_q [DEPTH];
	logic [AB-1:0] rd_q, wr_q;
	logic [CB-1:0] count_q;

	assign full = (count_q == CB'(DEPTH));
	assign nonempty = (count_q != '0);
	assign rdata = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q <= '0;
			wr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) wr_q <= (wr_q == AB'(DEPTH - 1)) ? '0 : wr_q + AB'(1);
			if (pop) rd_q <= (rd_q == AB'(DEPTH - 1)) ? '0 : rd_q + AB'(1);
			if (push && !pop) count_q <= count_q + CB'(1);
			else if (pop && !push) count_q <= count_q - CB'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= wdata;
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CB'(DEPTH))
		else $error("queue overflow");
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("push into full queue");
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> nonempty)
		else $error("pop from empty queue");

endmodule

// ===== rtl/pra_back.sv =====
// Rotation pipeline: five planar rotations, translate back and saturate.
module pra_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               q_valid,
	input  pra_pkg::point_t    q_data,
	output logic               q_pop,
	input  pra_pkg::coef_t     coef,
	input  logic signed [31:0] sx,
	input  logic signed [31:0] sy,
	input  logic signed [31:0] sz,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [127:0]       out_data
);
	localparam int NROT = pra_pkg::NROT;
	localparam int PW = pra_pkg::PW;
	localparam int PP = PW + pra_pkg::CW;
	localparam int NS = 2 * NROT + 1;
	localparam int CF = pra_pkg::COEF_FRAC;

	logic [NS:0] v_q;
	logic en;
	logic signed [PW-1:0] x_s [0:2*NROT];
	logic signed [PW-1:0] y_s [0:2*NROT];
	logic signed [PW-1:0] z_s [0:2*NROT];
	logic [31:0] w_s [0:2*NROT];
	logic signed [PP-1:0] pac_s [NROT];
	logic signed [PP-1:0] pbs_s [NROT];
	logic signed [PP-1:0] pas_s [NROT];
	logic signed [PP-1:0] pbc_s [NROT];
	logic [31:0] ox_q, oy_q, oz_q, ow_q;

	// Advance the whole pipe unless the output holds an untaken result
	assign en = !v_q[NS] || out_ready;
	assign q_pop = en && q_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else if (en) begin
			v_q <= {v_q[NS-1:0], q_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s[0] <= PW'(q_data.dx);
			y_s[0] <= PW'(q_data.dy);
			z_s[0] <= PW'(q_data.dz);
			w_s[0] <= q_data.w;
		end
	end

	for (genvar k = 0; k < NROT; k++) begin : g_rot
		logic signed [PW-1:0] a, b, na, nb;
		logic signed [PP:0] sa, sb;

		if (k % 2 == 0) begin : g_xy
			assign a = x_s[2*k];
			assign b = y_s[2*k];
		end else begin : g_yz
			assign a = y_s[2*k];
			assign b = z_s[2*k];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				pac_s[k] <= PP'(a) * PP'(coef.c[k]);
				pbs_s[k] <= PP'(b) * PP'(coef.s[k]);
				pas_s[k] <= PP'(a) * PP'(coef.s[k]);
				pbc_s[k] <= PP'(b) * PP'(coef.c[k]);
				x_s[2*k+1] <= x_s[2*k];
				y_s[2*k+1] <= y_s[2*k];
				z_s[2*k+1] <= z_s[2*k];
				w_s[2*k+1] <= w_s[2*k];
			end
		end

		always_comb begin
			sa = (PP+1)'(pac_s[k]) - (PP+1)'(pbs_s[k]) + ((PP+1)'(1) <<< (CF - 1));
			sb = (PP+1)'(pas_s[k]) + (PP+1)'(pbc_s[k]) + ((PP+1)'(1) <<< (CF - 1));
			na = PW'(sa >>> CF);
			nb = PW'(sb >>> CF);
		end

		always_ff @(posedge clk) begin
			if (en) begin
				w_s[2*k+2] <= w_s[2*k+1];
				if (k % 2 == 0) begin
					x_s[2*k+2] <= na;
					y_s[2*k+2] <= nb;
					z_s[2*k+2] <= z_s[2*k+1];
				end else begin
					x_s[2*k+2] <= x_s[2*k+1];
					y_s[2*k+2] <= na;
					z_s[2*k+2] <= nb;
				end
			end
		end
	end

	function automatic logic [31:0] sat32(input logic signed [PW:0] v);
		logic [31:0] r;
		if (v > (PW+1)'(32'sh7fffffff)) r = 32'h7fffffff;
		else if (v < (PW+1)'(-33'sh80000000)) r = 32'h80000000;
		else r = v[31:0];
		return r;
	endfunction

	always_ff @(posedge clk) begin
		if (en) begin
			ox_q <= sat32((PW+1)'(x_s[2*NROT]) + (PW+1)'(sx));
			oy_q <= sat32((PW+1)'(y_s[2*NROT]) + (PW+1)'(sy));
			oz_q <= sat32((PW+1)'(z_s[2*NROT]) + (PW+1)'(sz));
			ow_q <= w_s[2*NROT];
		end
	end

	assign out_valid = v_q[NS];
	assign out_data = {ow_q, oz_q, oy_q, ox_q};

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
		else $error("result dropped while stalled");
	a_pop_en: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |=> v_q[0])
		else $error("popped request lost");
	a_stall_no_pop: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |-> !q_pop)
		else $error("pop during stall");

endmodule

// ===== rtl/point_rotate_about_axis.sv =====
// Top level: configuration registers, request front end, queue and rotation pipeline.
// Pipeline: load from the queue, ten rotation stages, saturation register; throughput one
// point per cycle while the output is not stalled and the coefficients are ready.
// After reset and after every configuration write the coefficient sequencer recomputes
// the coefficients on its shared CORDIC; s_axis_tready is low then.
// Reset clears control state and loads the register reset values; the pipe empties.
module point_rotate_about_axis #(
	parameter int CORDIC_STEPS = pra_pkg::CORDIC_STEPS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [4:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [127:0] s_axis_tdata,  // in_x, in_y, in_z, in_weight
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [127:0] m_axis_tdata   // out_x, out_y, out_z, out_weight
);
	logic signed [31:0] sx_q, sy_q, sz_q, ex_q, ey_q, ez_q;
	logic signed [25:0] turn_q;
	logic wr, coef_ready, q_full, q_nonempty, q_pop, push;
	logic [2:0] ridx;
	pra_pkg::coef_t coef;
	pra_pkg::point_t pt, q_head;

	assign pready = 1'b1;
	assign wr = psel && penable && pwrite;
	assign ridx = paddr[4:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sx_q <= '0;
			sy_q <= '0;
			sz_q <= '0;
			ex_q <= '0;
			ey_q <= '0;
			ez_q <= 32'sd65536;
			turn_q <= '0;
		end else if (wr) begin
			unique case (ridx)
				pra_pkg::REG_SX: sx_q <= pwdata;
				pra_pkg::REG_SY: sy_q <= pwdata;
				pra_pkg::REG_SZ: sz_q <= pwdata;
				pra_pkg::REG_EX: ex_q <= pwdata;
				pra_pkg::REG_EY: ey_q <= pwdata;
				pra_pkg::REG_EZ: ez_q <= pwdata;
				pra_pkg::REG_TURN: turn_q <= pwdata[25:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (ridx)
			pra_pkg::REG_SX: prdata = sx_q;
			pra_pkg::REG_SY: prdata = sy_q;
			pra_pkg::REG_SZ: prdata = sz_q;
			pra_pkg::REG_EX: prdata = ex_q;
			pra_pkg::REG_EY: prdata = ey_q;
			pra_pkg::REG_EZ: prdata = ez_q;
			pra_pkg::REG_TURN: prdata = {6'd0, turn_q};
			default: prdata = '0;
		endcase
	end

	pra_coef #(.STEPS(CORDIC_STEPS)) u_coef (
		.clk(clk), .arst_n(arst_n), .start(wr),
		.sx(sx_q), .sy(sy_q), .sz(sz_q), .ex(ex_q), .ey(ey_q), .ez(ez_q),
		.turn(turn_q), .ready(coef_ready), .coef(coef)
	);

	// Move the point to the axis start before queueing
	assign pt.dx = 33'($signed(s_axis_tdata[31:0])) - 33'(sx_q);
	assign pt.dy = 33'($signed(s_axis_tdata[63:32])) - 33'(sy_q);
	assign pt.dz = 33'($signed(s_axis_tdata[95:64])) - 33'(sz_q);
	assign pt.w = s_axis_tdata[127:96];

	assign s_axis_tready = coef_ready && !q_full;
	assign push = s_axis_tvalid && s_axis_tready;

	pra_queue #(.W($bits(pra_pkg::point_t)), .DEPTH(pra_pkg::QDEPTH)) u_queue (
		.clk(clk), .arst_n(arst_n), .push(push), .wdata(pt), .pop(q_pop),
		.rdata(q_head), .full(q_full), .nonempty(q_nonempty)
	);

	pra_back u_back (
		.clk(clk), .arst_n(arst_n), .q_valid(q_nonempty), .q_data(q_head),
		.q_pop(q_pop), .coef(coef), .sx(sx_q), .sy(sy_q), .sz(sz_q),
		.out_valid(m_axis_tvalid), .out_ready(m_axis_tready), .out_data(m_axis_tdata)
	);

endmodule

// ===== tb/sv/point_rotate_about_axis_test.sv =====
// Self-checking testbench for the point rotation block: stream stimulus, APB setup, scoreboard.
`timescale 1ns / 100ps

module point_rotate_about_axis_test;

	localparam int STEPS = 18;
	localparam int STALL_LIMIT = 5000;
	localparam logic [2:0] REG_VOID = 3'd7;
	localparam longint FULL_TURN = 23592960;
	localparam longint HALF_TURN = 11796480;
	localparam longint QUARTER_TURN = 5898240;
	localparam longint RECIP_GAIN = 652032874;
	localparam longint ATAN_STEP [0:22] = '{
		2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
		14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7, 4, 2, 1
	};

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         psel = 1'b0;
	logic         penable = 1'b0;
	logic         pwrite = 1'b0;
	logic [4:0]   paddr = '0;
	logic [31:0]  pwdata = '0;
	logic [31:0]  prdata;
	logic         pready;
	logic         s_axis_tvalid = 1'b0;
	logic         s_axis_tready;
	logic [127:0] s_axis_tdata = '0;  // in_x, in_y, in_z, in_weight
	logic         m_axis_tvalid;
	logic         m_axis_tready = 1'b0;
	logic [127:0] m_axis_tdata;       // out_x, out_y, out_z, out_weight

	point_rotate_about_axis dut (.*);

	logic [127:0] pending_points [$];
	logic [127:0] rotated_points [$];
	longint       axis_reg [7];
	bit           quiet = 1'b0;
	int           fail_count = 0;
	int           points_in = 0;
	int           points_out = 0;
	int           setups = 0;
	int           stall_cycles = 0;

	initial begin
		forever #1 clk = ~clk;
	end

	function automatic longint sext_bits(logic [31:0] v, int w);
		longint r;
		r = longint'(v) & ((64'sd1 <<< w) - 1);
		if (r[w-1])
			r = r - (64'sd1 <<< w);
		return r;
	endfunction

	function automatic longint vector_len(longint x, longint y, output longint ang);
		longint z, xs, ys;
		z = 0;
		for (int i = 0; i < STEPS; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (y >= 0) begin
				x = x + ys; y = y - xs; z += ATAN_STEP[i];
			end else begin
				x = x - ys; y = y + xs; z -= ATAN_STEP[i];
			end
		end
		ang = z;
		return x;
	endfunction

	function automatic longint abs_angle(longint opp, longint adj);
		longint z, unused;
		if (adj == 0)
			return QUARTER_TURN;
		unused = vector_len(adj < 0 ? -adj : adj, opp < 0 ? -opp : opp, z);
		return z < 0 ? -z : z;
	endfunction

	function automatic void rotate_pair(inout longint a, inout longint b, input longint t);
		longint x, y, na, nb;
		bit flip;
		x = RECIP_GAIN;
		y = 0;
		flip = 1'b0;
		t = ((t % FULL_TURN) + FULL_TURN) % FULL_TURN;
		if (t > HALF_TURN)
			t -= FULL_TURN;
		if (t > QUARTER_TURN) begin
			t -= HALF_TURN; flip = 1'b1;
		end else if (t < -QUARTER_TURN) begin
			t += HALF_TURN; flip = 1'b1;
		end
		for (int i = 0; i < STEPS; i++) begin
			na = x >>> i;
			nb = y >>> i;
			if (t >= 0) begin
				x = x - nb; y = y + na; t -= ATAN_STEP[i];
			end else begin
				x = x + nb; y = y - na; t += ATAN_STEP[i];
			end
		end
		x = (x + 2) >>> 2;
		y = (y + 2) >>> 2;
		if (flip) begin
			x = -x; y = -y;
		end
		na = (a * x - b * y + (64'sd1 <<< 27)) >>> 28;
		nb = (a * y + b * x + (64'sd1 <<< 27)) >>> 28;
		a = na;
		b = nb;
	endfunction

	function automatic logic [31:0] clamp32(longint v);
		if (v > 64'sd2147483647)
			v = 64'sd2147483647;
		if (v < -64'sd2147483648)
			v = -64'sd2147483648;
		return v[31:0];
	endfunction

	function automatic logic [127:0] rotate_point(logic [127:0] p);
		longint vx, vy, vz, za, xa, len, unused, px, py, pz;
		vx = axis_reg[pra_pkg::REG_EX] - axis_reg[pra_pkg::REG_SX];
		vy = axis_reg[pra_pkg::REG_EY] - axis_reg[pra_pkg::REG_SY];
		vz = axis_reg[pra_pkg::REG_EZ] - axis_reg[pra_pkg::REG_SZ];
		px = sext_bits(p[31:0], 32) - axis_reg[pra_pkg::REG_SX];
		py = sext_bits(p[63:32], 32) - axis_reg[pra_pkg::REG_SY];
		pz = sext_bits(p[95:64], 32) - axis_reg[pra_pkg::REG_SZ];
		za = abs_angle(vx, vy);
		len = vector_len(vx < 0 ? -vx : vx, vy < 0 ? -vy : vy, unused);
		len = (len * RECIP_GAIN + (64'sd1 <<< 29)) >>> 30;
		xa = abs_angle(len, vz);
		if (vy < 0)
			za = HALF_TURN - za;
		if (vx < 0)
			za = -za;
		if (vz < 0)
			xa = HALF_TURN - xa;
		rotate_pair(px, py, za);
		rotate_pair(py, pz, xa);
		rotate_pair(px, py, axis_reg[pra_pkg::REG_TURN]);
		rotate_pair(py, pz, -xa);
		rotate_pair(px, py, -za);
		return {p[127:96], clamp32(pz + axis_reg[pra_pkg::REG_SZ]),
			clamp32(py + axis_reg[pra_pkg::REG_SY]), clamp32(px + axis_reg[pra_pkg::REG_SX])};
	endfunction

	// sender: hold a request until it is taken, predict at acceptance
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				rotated_points.push_back(rotate_point(s_axis_tdata));
				points_in++;
			end
			if (!s_axis_tvalid || s_axis_tready) begin
				if (pending_points.size() > 0 && (quiet || $urandom_range(99) >= 19)) begin
					s_axis_tdata <= pending_points.pop_front();
					s_axis_tvalid <= 1'b1;
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// receiver: random back-pressure, compare against oldest prediction
	always @(posedge clk or negedge arst_n) begin
		logic [127:0] want;
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				points_out++;
				if (rotated_points.size() == 0) begin
					$error("unexpected result %h", m_axis_tdata);
					fail_count++;
				end else begin
					want = rotated_points.pop_front();
					if (want[31:0] !== m_axis_tdata[31:0]) begin
						$error("out_x: expected %h, got %h", want[31:0], m_axis_tdata[31:0]);
						fail_count++;
					end
					if (want[63:32] !== m_axis_tdata[63:32]) begin
						$error("out_y: expected %h, got %h", want[63:32], m_axis_tdata[63:32]);
						fail_count++;
					end
					if (want[95:64] !== m_axis_tdata[95:64]) begin
						$error("out_z: expected %h, got %h", want[95:64], m_axis_tdata[95:64]);
						fail_count++;
					end
					if (want[127:96] !== m_axis_tdata[127:96]) begin
						$error("out_weight: expected %h, got %h",
							want[127:96], m_axis_tdata[127:96]);
						fail_count++;
					end
				end
			end
			m_axis_tready <= quiet || ($urandom_range(99) >= 19);
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || psel)
				stall_cycles <= 0;
			else
				stall_cycles <= stall_cycles + 1;
			if (stall_cycles > STALL_LIMIT) begin
				$display("point_rotate_about_axis: mismatch");
				$finish;
			end
		end
	end

	task automatic reg_write(logic [2:0] idx, logic [31:0] value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (idx != REG_VOID)
			axis_reg[idx] = sext_bits(value, idx == pra_pkg::REG_TURN ? 26 : 32);
		setups++;
	endtask

	task automatic drain;
		wait (pending_points.size() == 0 && !s_axis_tvalid && rotated_points.size() == 0);
		repeat (20) @(posedge clk);
	endtask

	function automatic logic [31:0] pick_coord(int mode);
		case (mode)
			0: return $urandom();
			1: return $urandom_range(1, 0) ? 32'h7fffffff : 32'h80000000;
			default: return 32'($signed($urandom_range(2097152)) - 1048576);
		endcase
	endfunction

	task automatic load_random(int count);
		int mode;
		for (int i = 0; i < count; i++) begin
			mode = ($urandom_range(9) < 3) ? 0 : (($urandom_range(19) == 0) ? 1 : 2);
			pending_points.push_back({32'($urandom()), pick_coord(mode),
				pick_coord(mode), pick_coord(mode)});
		end
	endtask

	task automatic random_axis;
		int mode;
		mode = $urandom_range(2) == 0 ? 0 : 2;
		reg_write(pra_pkg::REG_SX, pick_coord(mode));
		reg_write(pra_pkg::REG_SY, pick_coord(mode));
		reg_write(pra_pkg::REG_SZ, pick_coord(mode));
		reg_write(pra_pkg::REG_EX, pick_coord(mode));
		reg_write(pra_pkg::REG_EY, pick_coord(mode));
		reg_write(pra_pkg::REG_EZ, pick_coord(mode));
		reg_write(pra_pkg::REG_TURN, 32'($signed($urandom_range(47185920)) - 23592960));
	endtask

	initial begin
		axis_reg = '{0, 0, 0, 0, 0, 65536, 0};
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// reset axis along z, no turn: extremes of each field
		pending_points.push_back('0);
		pending_points.push_back({4{32'h7fffffff}});
		pending_points.push_back({4{32'h80000000}});
		pending_points.push_back({4{32'hffffffff}});
		pending_points.push_back({32'h00010000, 32'h0, 32'h0, 32'h00010000});
		drain();

		// quarter turn; stray register write must be ignored
		reg_write(pra_pkg::REG_TURN, 32'd5898240);
		reg_write(REG_VOID, 32'hdeadbeef);
		pending_points.push_back({32'h00010000, 32'h0, 32'h0, 32'h00010000});
		pending_points.push_back({32'h0, 32'h7fffffff, 32'h7fffffff, 32'h80000000});
		pending_points.push_back({32'h12345678, 32'h00030000, 32'hfffe0000, 32'h00050000});
		drain();

		// degenerate axis, angle at both ends of the range
		reg_write(pra_pkg::REG_EZ, 32'h0);
		reg_write(pra_pkg::REG_TURN, 32'd23592960);
		pending_points.push_back({32'h0, 32'h00020000, 32'h00010000, 32'h00030000});
		drain();
		reg_write(pra_pkg::REG_TURN, 32'hfe980000);
		pending_points.push_back({32'h0, 32'h00020000, 32'h00010000, 32'h00030000});
		drain();

		// angle beyond one full turn both ways, axis in the x-y plane and reversed
		reg_write(pra_pkg::REG_EX, 32'hffff0000);
		reg_write(pra_pkg::REG_EY, 32'hfffe0000);
		reg_write(pra_pkg::REG_TURN, 32'h01ffffff);
		pending_points.push_back({32'h1, 32'h00010000, 32'h00070000, 32'hfff90000});
		drain();
		reg_write(pra_pkg::REG_TURN, 32'h02000000);
		reg_write(pra_pkg::REG_EY, 32'h0);
		pending_points.push_back({32'h1, 32'h00010000, 32'h00070000, 32'hfff90000});
		drain();

		// widest axis span, saturating results
		reg_write(pra_pkg::REG_SX, 32'h80000000);
		reg_write(pra_pkg::REG_SY, 32'h80000000);
		reg_write(pra_pkg::REG_SZ, 32'h7fffffff);
		reg_write(pra_pkg::REG_EX, 32'h7fffffff);
		reg_write(pra_pkg::REG_EY, 32'h7fffffff);
		reg_write(pra_pkg::REG_EZ, 32'h80000000);
		reg_write(pra_pkg::REG_TURN, 32'd2949120);
		pending_points.push_back({4{32'h7fffffff}});
		pending_points.push_back({4{32'h80000000}});
		pending_points.push_back('0);
		load_random(150);
		drain();

		for (int phase = 0; phase < 10; phase++) begin
			random_axis();
			quiet = (phase == 3);
			load_random(180);
			drain();
		end
		quiet = 1'b0;

		drain();
		$display("covered %0d points over %0d register writes, mixed axes and angles",
			points_in, setups);
		$display("results checked: %0d, failures: %0d", points_out, fail_count);
		if (fail_count == 0)
			$display("point_rotate_about_axis: match");
		else
			$display("point_rotate_about_axis: mismatch");
		$finish;
	end

endmodule
